// ===== rtl/jbc_pkg.sv =====
// Shared constants, codes and types for the JSON bracket checker.
// Used by the nesting stack, the top level and the port checker; no dependencies.
package jbc_pkg;

  localparam int MAX_DEPTH = 64;
  localparam int DEPTH_W   = $clog2(MAX_DEPTH + 1);
  localparam int ADDR_W    = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;

  localparam int LINE_W  = 24;
  localparam int COL_W   = 16;
  localparam int TALLY_W = 16;
  localparam int STAT_W  = 3;

  localparam logic [STAT_W-1:0] ST_VALID        = 3'd0;
  localparam logic [STAT_W-1:0] ST_BAD_BRACE    = 3'd1;
  localparam logic [STAT_W-1:0] ST_BAD_BRACKET  = 3'd2;
  localparam logic [STAT_W-1:0] ST_OPEN_BRACKET = 3'd3;
  localparam logic [STAT_W-1:0] ST_OPEN_STRING  = 3'd4;
  localparam logic [STAT_W-1:0] ST_TOO_DEEP     = 3'd5;

  localparam logic [7:0] CH_LF      = 8'h0A;
  localparam logic [7:0] CH_TAB     = 8'h09;
  localparam logic [7:0] CH_CR      = 8'h0D;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_COMMA   = 8'h2C;
  localparam logic [7:0] CH_QUOTE   = 8'h22;
  localparam logic [7:0] CH_BSLASH  = 8'h5C;
  localparam logic [7:0] CH_LBRACE  = 8'h7B;
  localparam logic [7:0] CH_RBRACE  = 8'h7D;
  localparam logic [7:0] CH_LBRACK  = 8'h5B;
  localparam logic [7:0] CH_RBRACK  = 8'h5D;
  localparam logic [7:0] CTRL_LIMIT = 8'h20;

  typedef struct packed {
    logic push;
    logic pop;
    logic push_bit;
  } stack_ctl_t;

endpackage

// ===== rtl/jbc_stack.sv =====
// Nesting stack: a synchronous memory of brace/bracket entries plus a cached top entry.
// The memory is read every cycle at the entry below the next top. Depends on jbc_pkg.
module jbc_stack import jbc_pkg::*; (
  input  logic              clk,
  input  stack_ctl_t        ctl,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic              top_bit,
  output logic              below_bit
);

  logic mem [MAX_DEPTH];

  always_ff @(posedge clk) begin
    if (ctl.push) begin
      mem[wr_addr] <= ctl.push_bit;
    end
    below_bit <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (ctl.push) begin
      top_bit <= ctl.push_bit;
    end else if (ctl.pop) begin
      top_bit <= below_bit;
    end
  end

endmodule

// ===== rtl/json_bracket_checker.sv =====
// Top level of the JSON bracket checker: byte scanner, counters and verdict output stage.
// Depends on jbc_pkg and jbc_stack.
//
//   channel  valid      stall      payload
//   input    in_valid   in_stall   data_byte, last
//   output   out_valid  out_stall  status, bad_line, bad_column, control_count,
//                                  first_control_line, dangling_comma
//
// Takes one byte per cycle while in_stall is low; a last byte's verdict is registered.
// The top of stack sits in a register and the memory read runs one entry below it,
// so pushes and pops follow each other at full rate with no read stall.
// A two-entry output stage holds verdicts; in_stall rises only when both are full.
// Reset is synchronous and needs no clearing pass over the stack memory.
module json_bracket_checker import jbc_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         data_byte,
  input  logic               last,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [STAT_W-1:0]  status,
  output logic [LINE_W-1:0]  bad_line,
  output logic [COL_W-1:0]   bad_column,
  output logic [TALLY_W-1:0] control_count,
  output logic [LINE_W-1:0]  first_control_line,
  output logic               dangling_comma
);

  typedef struct packed {
    logic [STAT_W-1:0]  status;
    logic [LINE_W-1:0]  line;
    logic [COL_W-1:0]   column;
    logic [TALLY_W-1:0] tally;
    logic [LINE_W-1:0]  first_line;
    logic               comma;
  } verdict_t;

  localparam logic [LINE_W-1:0]  LINE_MAX  = '1;
  localparam logic [COL_W-1:0]   COL_MAX   = '1;
  localparam logic [TALLY_W-1:0] TALLY_MAX = '1;

  logic [DEPTH_W-1:0] depth, depth_next;
  logic               in_str, in_str_next;
  logic               esc, esc_next;
  logic [LINE_W-1:0]  line, line_next;
  logic [COL_W-1:0]   col, col_next;
  logic [STAT_W-1:0]  err, err_next;
  logic [LINE_W-1:0]  err_line, err_line_next;
  logic [COL_W-1:0]   err_col, err_col_next;
  logic [TALLY_W-1:0] tally, tally_next;
  logic [LINE_W-1:0]  first_ctl, first_ctl_next;
  logic               comma_wait, comma_wait_next;
  logic               comma_seen, comma_seen_next;

  stack_ctl_t         sctl;
  logic               top_bit, below_bit;
  logic [DEPTH_W-1:0] rd_depth;
  logic               accept, take;
  verdict_t           verdict, skid;
  logic               skid_valid;
  logic               is_space;

  assign accept   = in_valid && !in_stall;
  assign take     = out_valid && !out_stall;
  assign in_stall = skid_valid;
  assign is_space = (data_byte == CH_SPACE) || (data_byte inside {[CH_TAB:CH_CR]});
  assign rd_depth = depth_next - DEPTH_W'(2);

  jbc_stack u_stack (
    .clk       (clk),
    .ctl       (sctl),
    .wr_addr   (depth[ADDR_W-1:0]),
    .rd_addr   (rd_depth[ADDR_W-1:0]),
    .top_bit   (top_bit),
    .below_bit (below_bit)
  );

  always_comb begin
    depth_next      = depth;
    in_str_next     = in_str;
    esc_next        = esc;
    line_next       = line;
    col_next        = col;
    err_next        = err;
    err_line_next   = err_line;
    err_col_next    = err_col;
    tally_next      = tally;
    first_ctl_next  = first_ctl;
    comma_wait_next = comma_wait;
    comma_seen_next = comma_seen;
    sctl            = '0;
    sctl.push_bit   = (data_byte == CH_LBRACE);
    verdict         = '0;

    if (accept) begin
      if (data_byte == CH_LF) begin
        if (line != LINE_MAX) line_next = line + LINE_W'(1);
        col_next = '0;
      end else if (col != COL_MAX) begin
        col_next = col + COL_W'(1);
      end

      if (data_byte == CH_COMMA) begin
        comma_wait_next = 1'b1;
      end else if (data_byte == CH_RBRACE || data_byte == CH_RBRACK) begin
        if (comma_wait) comma_seen_next = 1'b1;
        comma_wait_next = 1'b0;
      end else if (!is_space) begin
        comma_wait_next = 1'b0;
      end

      if (err == ST_VALID) begin
        if (esc) begin
          esc_next = 1'b0;
        end else if (data_byte == CH_BSLASH && in_str) begin
          esc_next = 1'b1;
        end else if (data_byte == CH_QUOTE) begin
          in_str_next = !in_str;
        end else if (in_str) begin
          if (data_byte < CTRL_LIMIT && data_byte != CH_TAB && data_byte != CH_LF &&
              data_byte != CH_CR) begin
            if (tally == '0) first_ctl_next = line_next;
            if (tally != TALLY_MAX) tally_next = tally + TALLY_W'(1);
          end
        end else if (data_byte == CH_LBRACE || data_byte == CH_LBRACK) begin
          if (depth == DEPTH_W'(MAX_DEPTH)) begin
            err_next      = ST_TOO_DEEP;
            err_line_next = line_next;
            err_col_next  = col_next;
          end else begin
            sctl.push  = 1'b1;
            depth_next = depth + DEPTH_W'(1);
          end
        end else if (data_byte == CH_RBRACE || data_byte == CH_RBRACK) begin
          if (depth == '0 || top_bit != (data_byte == CH_RBRACE)) begin
            err_next      = (data_byte == CH_RBRACE) ? ST_BAD_BRACE : ST_BAD_BRACKET;
            err_line_next = line_next;
            err_col_next  = col_next;
          end else begin
            sctl.pop   = 1'b1;
            depth_next = depth - DEPTH_W'(1);
          end
        end
      end

      if (last) begin
        verdict.status = err_next;
        if (err_next == ST_VALID) begin
          if (depth_next != '0) verdict.status = ST_OPEN_BRACKET;
          else if (in_str_next) verdict.status = ST_OPEN_STRING;
        end
        verdict.line       = err_line_next;
        verdict.column     = err_col_next;
        verdict.tally      = tally_next;
        verdict.first_line = first_ctl_next;
        verdict.comma      = (verdict.status == ST_VALID) && comma_seen_next;

        depth_next      = '0;
        in_str_next     = 1'b0;
        esc_next        = 1'b0;
        line_next       = LINE_W'(1);
        col_next        = '0;
        err_next        = ST_VALID;
        err_line_next   = '0;
        err_col_next    = '0;
        tally_next      = '0;
        first_ctl_next  = '0;
        comma_wait_next = 1'b0;
        comma_seen_next = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      depth      <= '0;
      in_str     <= 1'b0;
      esc        <= 1'b0;
      line       <= LINE_W'(1);
      col        <= '0;
      err        <= ST_VALID;
      err_line   <= '0;
      err_col    <= '0;
      tally      <= '0;
      first_ctl  <= '0;
      comma_wait <= 1'b0;
      comma_seen <= 1'b0;
    end else begin
      depth      <= depth_next;
      in_str     <= in_str_next;
      esc        <= esc_next;
      line       <= line_next;
      col        <= col_next;
      err        <= err_next;
      err_line   <= err_line_next;
      err_col    <= err_col_next;
      tally      <= tally_next;
      first_ctl  <= first_ctl_next;
      comma_wait <= comma_wait_next;
      comma_seen <= comma_seen_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (take || !out_valid) begin
      if (skid_valid) begin
        out_valid          <= 1'b1;
        status             <= skid.status;
        bad_line           <= skid.line;
        bad_column         <= skid.column;
        control_count      <= skid.tally;
        first_control_line <= skid.first_line;
        dangling_comma     <= skid.comma;
        skid_valid         <= 1'b0;
      end else if (accept && last) begin
        out_valid          <= 1'b1;
        status             <= verdict.status;
        bad_line           <= verdict.line;
        bad_column         <= verdict.column;
        control_count      <= verdict.tally;
        first_control_line <= verdict.first_line;
        dangling_comma     <= verdict.comma;
      end else begin
        out_valid <= 1'b0;
      end
    end else if (accept && last) begin
      skid       <= verdict;
      skid_valid <= 1'b1;
    end
  end

endmodule

// ===== rtl/jbc_checker.sv =====
// Port-level assertions for the JSON bracket checker, bound to the top level.
// Depends on jbc_pkg and json_bracket_checker.
module jbc_checker import jbc_pkg::*; (
  input logic               clk,
  input logic               rst,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input logic [STAT_W-1:0]  status,
  input logic [LINE_W-1:0]  bad_line,
  input logic [COL_W-1:0]   bad_column,
  input logic [TALLY_W-1:0] control_count,
  input logic [LINE_W-1:0]  first_control_line,
  input logic               dangling_comma
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(status) && $stable(bad_line))
    else $error("Stalled output beat changed.");

  a_stall_needs_result: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && $past(out_valid))
    else $error("Input stalled with no pending verdict.");

  a_no_location: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == ST_VALID || status == ST_OPEN_BRACKET || status == ST_OPEN_STRING)
    |-> bad_line == '0 && bad_column == '0)
    else $error("Location reported for an error without one.");

  a_comma_only_valid: assert property (@(posedge clk) disable iff (rst)
    out_valid && dangling_comma |-> status == ST_VALID)
    else $error("Trailing comma reported on an invalid document.");

  a_control_line: assert property (@(posedge clk) disable iff (rst)
    out_valid && control_count == '0 |-> first_control_line == '0)
    else $error("Control line set with no control bytes.");

endmodule

bind json_bracket_checker jbc_checker u_jbc_checker (
  .clk                (clk),
  .rst                (rst),
  .in_stall           (in_stall),
  .out_valid          (out_valid),
  .out_stall          (out_stall),
  .status             (status),
  .bad_line           (bad_line),
  .bad_column         (bad_column),
  .control_count      (control_count),
  .first_control_line (first_control_line),
  .dangling_comma     (dangling_comma)
);

// ===== tb/tb_json_bracket_checker.sv =====
// Self-checking testbench for json_bracket_checker: drives byte streams of JSON documents
// and compares every verdict with a document tracker kept inside this file.
// Depends on jbc_pkg and the json_bracket_checker RTL.
module tb_json_bracket_checker;
  import jbc_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int TARGET_BYTES = 1150;
  localparam int LONG_HOLD = 400;

  typedef struct {
    logic [7:0] data;
    logic       last;
    logic       drain_before;
    logic       hold_rx;
    logic       quiet;
  } doc_byte_t;

  typedef struct {
    logic [STAT_W-1:0]  status;
    logic [LINE_W-1:0]  line;
    logic [COL_W-1:0]   column;
    logic [TALLY_W-1:0] controls;
    logic [LINE_W-1:0]  control_line;
    logic               comma;
  } verdict_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [7:0]         data_byte = '0;
  logic               last = 1'b0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [STAT_W-1:0]  status;
  logic [LINE_W-1:0]  bad_line;
  logic [COL_W-1:0]   bad_column;
  logic [TALLY_W-1:0] control_count;
  logic [LINE_W-1:0]  first_control_line;
  logic               dangling_comma;

  logic hold_req = 1'b0;
  logic quiet_mode = 1'b0;

  doc_byte_t  pending_bytes[$];
  verdict_t   verdicts_due[$];
  logic [7:0] doc[$];
  logic       next_drain = 1'b0;
  logic       next_hold = 1'b0;
  logic       in_quiet = 1'b0;

  bit                 open_kind[MAX_DEPTH];
  int                 open_count;
  bit                 in_quote;
  bit                 escaped;
  logic [LINE_W-1:0]  line_no;
  logic [COL_W-1:0]   col_no;
  logic [STAT_W-1:0]  fault;
  logic [LINE_W-1:0]  fault_line;
  logic [COL_W-1:0]   fault_col;
  logic [TALLY_W-1:0] ctl_count;
  logic [LINE_W-1:0]  ctl_line;
  bit                 comma_pending;
  bit                 comma_found;

  int mismatches = 0;
  int docs_made = 0;
  int bytes_sent = 0;
  int verdicts_checked = 0;
  int status_hits[8];
  int cycles = 0;
  int tx_gap = 0;
  int tx_calm = 0;
  int rx_gap = 0;
  int rx_calm = 0;
  int long_hold = 0;

  logic [7:0] blanks[6] = '{CH_SPACE, CH_TAB, CH_LF, 8'h0B, 8'h0C, CH_CR};
  logic [7:0] nest_chars[4] = '{CH_LBRACE, CH_RBRACE, CH_LBRACK, CH_RBRACK};

  json_bracket_checker u_top (
    .clk                (clk),
    .rst                (rst),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .data_byte          (data_byte),
    .last               (last),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .status             (status),
    .bad_line           (bad_line),
    .bad_column         (bad_column),
    .control_count      (control_count),
    .first_control_line (first_control_line),
    .dangling_comma     (dangling_comma)
  );

  always #5 clk = ~clk;

  task automatic restart_document();
    open_count = 0;
    in_quote = 1'b0;
    escaped = 1'b0;
    line_no = LINE_W'(1);
    col_no = '0;
    fault = ST_VALID;
    fault_line = '0;
    fault_col = '0;
    ctl_count = '0;
    ctl_line = '0;
    comma_pending = 1'b0;
    comma_found = 1'b0;
  endtask

  task automatic mark_fault(input logic [STAT_W-1:0] code);
    fault = code;
    fault_line = line_no;
    fault_col = col_no;
  endtask

  task automatic track_byte(input logic [7:0] c, input logic is_last);
    verdict_t v;
    if (c == CH_LF) begin
      if (line_no != {LINE_W{1'b1}}) line_no++;
      col_no = '0;
    end else if (col_no != {COL_W{1'b1}}) begin
      col_no++;
    end
    if (c == CH_COMMA) begin
      comma_pending = 1'b1;
    end else if (c == CH_RBRACE || c == CH_RBRACK) begin
      if (comma_pending) comma_found = 1'b1;
      comma_pending = 1'b0;
    end else if (!(c == CH_SPACE || (c >= CH_TAB && c <= CH_CR))) begin
      comma_pending = 1'b0;
    end
    if (fault == ST_VALID) begin
      if (escaped) begin
        escaped = 1'b0;
      end else if (c == CH_BSLASH && in_quote) begin
        escaped = 1'b1;
      end else if (c == CH_QUOTE) begin
        in_quote = !in_quote;
      end else if (in_quote) begin
        if (c < CTRL_LIMIT && c != CH_TAB && c != CH_LF && c != CH_CR) begin
          if (ctl_count == '0) ctl_line = line_no;
          if (ctl_count != {TALLY_W{1'b1}}) ctl_count++;
        end
      end else if (c == CH_LBRACE || c == CH_LBRACK) begin
        if (open_count >= MAX_DEPTH) begin
          mark_fault(ST_TOO_DEEP);
        end else begin
          open_kind[open_count] = (c == CH_LBRACE);
          open_count++;
        end
      end else if (c == CH_RBRACE) begin
        if (open_count == 0 || !open_kind[open_count-1]) mark_fault(ST_BAD_BRACE);
        else open_count--;
      end else if (c == CH_RBRACK) begin
        if (open_count == 0 || open_kind[open_count-1]) mark_fault(ST_BAD_BRACKET);
        else open_count--;
      end
    end
    if (is_last) begin
      if (fault == ST_VALID) begin
        if (open_count != 0) fault = ST_OPEN_BRACKET;
        else if (in_quote) fault = ST_OPEN_STRING;
      end
      v.status = fault;
      v.line = fault_line;
      v.column = fault_col;
      v.controls = ctl_count;
      v.control_line = ctl_line;
      v.comma = (fault == ST_VALID) && comma_found;
      verdicts_due.insert(verdicts_due.size(), v);
      restart_document();
    end
  endtask

  function automatic void check_field(string what, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
    end
  endfunction

  // Byte driver.
  always @(posedge clk) begin : tx_side
    doc_byte_t nxt;
    logic      go;
    logic      want_hold;
    go = 1'b0;
    want_hold = 1'b0;
    if (rst) begin
      in_valid <= 1'b0;
      hold_req <= 1'b0;
      tx_gap = 0;
      tx_calm = 0;
      restart_document();
    end else begin
      if (in_valid && !in_stall) begin
        track_byte(data_byte, last);
        bytes_sent++;
      end
      if (!(in_valid && in_stall)) begin
        if (tx_gap > 0) begin
          tx_gap--;
        end else if (pending_bytes.size() != 0 &&
                     !(pending_bytes[0].drain_before && verdicts_due.size() != 0)) begin
          if (tx_calm > 0) tx_calm--;
          else if (!pending_bytes[0].quiet && $urandom_range(0, 60) == 0)
            tx_calm = $urandom_range(30, 150);
          if (!pending_bytes[0].quiet && tx_calm == 0 && $urandom_range(0, 5) == 0) begin
            tx_gap = $urandom_range(0, 14);
          end else begin
            nxt = pending_bytes.pop_front();
            go = 1'b1;
            data_byte <= nxt.data;
            last <= nxt.last;
            quiet_mode <= nxt.quiet;
            want_hold = nxt.hold_rx;
          end
        end
        in_valid <= go;
      end
      hold_req <= want_hold;
    end
  end

  // Verdict side back-pressure.
  always @(posedge clk) begin : rx_side
    logic stall_now;
    stall_now = 1'b0;
    if (rst) begin
      out_stall <= 1'b0;
      rx_gap = 0;
      rx_calm = 0;
      long_hold = 0;
    end else begin
      if (hold_req) long_hold = LONG_HOLD;
      if (long_hold > 0) begin
        long_hold--;
        stall_now = 1'b1;
      end else if (rx_gap > 0) begin
        rx_gap--;
        stall_now = 1'b1;
      end else if (quiet_mode) begin
        stall_now = 1'b0;
      end else if (rx_calm > 0) begin
        rx_calm--;
      end else if ($urandom_range(0, 80) == 0) begin
        rx_calm = $urandom_range(30, 150);
      end else if ($urandom_range(0, 5) == 0) begin
        rx_gap = $urandom_range(0, 14);
        stall_now = 1'b1;
      end
      out_stall <= stall_now;
    end
  end

  // Verdict checker.
  always @(posedge clk) begin : verdict_check
    verdict_t want;
    if (!rst && out_valid && !out_stall) begin
      if (verdicts_due.size() == 0) begin
        mismatches++;
        $display("%0t: verdict with none expected, status %0d", $time, status);
      end else begin
        want = verdicts_due.pop_front();
        verdicts_checked++;
        status_hits[want.status]++;
        check_field("status", 32'(want.status), 32'(status));
        check_field("bad_line", 32'(want.line), 32'(bad_line));
        check_field("bad_column", 32'(want.column), 32'(bad_column));
        check_field("control_count", 32'(want.controls), 32'(control_count));
        check_field("first_control_line", 32'(want.control_line),
                    32'(first_control_line));
        check_field("dangling_comma", 32'(want.comma), 32'(dangling_comma));
      end
    end
  end

  always @(posedge clk) begin : watchdog
    cycles++;
    if (cycles == CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d verdicts outstanding", cycles,
               verdicts_due.size());
      $display("DONE: errors detected");
      $finish;
    end
  end

  task automatic add_byte(input logic [7:0] b);
    doc.insert(doc.size(), b);
  endtask

  task automatic emit_doc();
    doc_byte_t it;
    if (doc.size() == 0) add_byte(CH_SPACE);
    foreach (doc[i]) begin
      it.data = doc[i];
      it.last = (i == doc.size() - 1);
      it.drain_before = (i == 0) && next_drain;
      it.hold_rx = (i == 0) && next_hold;
      it.quiet = in_quiet;
      pending_bytes.insert(pending_bytes.size(), it);
    end
    next_drain = 1'b0;
    next_hold = 1'b0;
    doc.delete();
    docs_made++;
  endtask

  task automatic add_text(input string s);
    for (int i = 0; i < s.len(); i++) add_byte(s[i]);
  endtask

  task automatic add_string();
    int m;
    add_byte(CH_QUOTE);
    m = $urandom_range(0, 8);
    repeat (m) begin
      case ($urandom_range(0, 9))
        0: add_byte(8'($urandom_range(0, 31)));
        1: begin
          add_byte(CH_BSLASH);
          add_byte(8'($urandom_range(0, 255)));
        end
        2: add_byte(8'($urandom_range(128, 255)));
        3: add_byte(nest_chars[$urandom_range(0, 3)]);
        4: add_byte(CH_LF);
        5: add_byte(CH_COMMA);
        default: add_byte(8'($urandom_range(8'h61, 8'h7A)));
      endcase
    end
    add_byte(CH_QUOTE);
  endtask

  task automatic gen_json();
    bit kinds[$];
    bit k;
    int n;
    n = $urandom_range(1, 16);
    repeat (n) begin
      case ($urandom_range(0, 11))
        0, 1: if (kinds.size() < 12) begin
          k = 1'($urandom_range(0, 1));
          kinds.insert(kinds.size(), k);
          add_byte(k ? CH_LBRACE : CH_LBRACK);
        end
        2, 3: if (kinds.size() > 0) add_byte(kinds.pop_back() ? CH_RBRACE : CH_RBRACK);
        4, 5: add_string();
        6: begin
          add_byte(CH_COMMA);
          repeat ($urandom_range(0, 2)) add_byte(blanks[$urandom_range(0, 5)]);
          if (kinds.size() > 0) add_byte(kinds.pop_back() ? CH_RBRACE : CH_RBRACK);
        end
        7: add_byte(CH_COMMA);
        8: add_byte(blanks[$urandom_range(0, 5)]);
        9: add_byte(8'($urandom_range(8'h30, 8'h39)));
        10: add_byte(8'h3A);
        default: add_byte(8'($urandom_range(128, 255)));
      endcase
    end
    case ($urandom_range(0, 9))
      7: begin
        if (kinds.size() > 0 && kinds[$]) add_byte(CH_RBRACK);
        else add_byte(CH_RBRACE);
      end
      8: add_byte(CH_QUOTE);
      9: ;
      default: while (kinds.size() > 0) add_byte(kinds.pop_back() ? CH_RBRACE : CH_RBRACK);
    endcase
    emit_doc();
  endtask

  task automatic gen_noise();
    repeat ($urandom_range(1, 20)) add_byte(8'($urandom_range(0, 255)));
    emit_doc();
  endtask

  task automatic gen_deep(input bit overflow);
    bit kinds[$];
    bit k;
    repeat (MAX_DEPTH) begin
      k = 1'($urandom_range(0, 1));
      kinds.insert(kinds.size(), k);
      add_byte(k ? CH_LBRACE : CH_LBRACK);
    end
    if (overflow) begin
      add_byte(CH_LBRACK);
      add_byte(CH_QUOTE);
      add_byte(8'h01);
      add_byte(CH_RBRACK);
      add_byte(CH_LF);
    end else begin
      while (kinds.size() > 0) add_byte(kinds.pop_back() ? CH_RBRACE : CH_RBRACK);
    end
    emit_doc();
  endtask

  initial begin : stimulus
    bit pressure_done;
    bit deep_done;
    bit drain_done;
    pressure_done = 1'b0;
    deep_done = 1'b0;
    drain_done = 1'b0;

    add_text("{\"k\":[1, ]}");
    emit_doc();
    add_text("]");
    emit_doc();
    add_text("}");
    emit_doc();
    add_text("[}x");
    emit_doc();
    add_text("{]");
    emit_doc();
    add_text("\"\\\"");
    add_byte(8'h01);
    emit_doc();
    add_text("[\n{");
    emit_doc();
    add_byte(8'hFF);
    emit_doc();
    add_byte(8'h00);
    emit_doc();

    while (pending_bytes.size() < TARGET_BYTES) begin
      if (!pressure_done && pending_bytes.size() > 300) begin
        pressure_done = 1'b1;
        next_drain = 1'b1;
        next_hold = 1'b1;
        repeat (40) begin
          add_byte(8'($urandom_range(0, 255)));
          emit_doc();
        end
      end else if (!deep_done && pending_bytes.size() > 600) begin
        deep_done = 1'b1;
        gen_deep(1'b0);
        gen_deep(1'b1);
      end else if (!drain_done && pending_bytes.size() > 900) begin
        drain_done = 1'b1;
        next_drain = 1'b1;
        gen_json();
      end else if ($urandom_range(0, 4) == 0) begin
        gen_noise();
      end else begin
        gen_json();
      end
    end

    in_quiet = 1'b1;
    repeat (5) gen_json();

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    while (pending_bytes.size() != 0 || in_valid) @(posedge clk);
    while (verdicts_due.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("Ran %0d documents, %0d bytes, %0d verdicts checked in %0d cycles.",
             docs_made, bytes_sent, verdicts_checked, cycles);
    $display("Verdicts: valid %0d, bad brace %0d, bad bracket %0d, open nest %0d, %s %0d, %s %0d",
             status_hits[ST_VALID], status_hits[ST_BAD_BRACE], status_hits[ST_BAD_BRACKET],
             status_hits[ST_OPEN_BRACKET], "open string", status_hits[ST_OPEN_STRING],
             "too deep", status_hits[ST_TOO_DEEP]);
    if (mismatches == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
